// File: rtl/spq_pkg.sv
// stable priority queue: shared types and default constants
// item structs for the command and result channels, cell control struct
// no dependencies
package spq_pkg;

  localparam int unsigned DEF_CAPACITY      = 16;
  localparam int unsigned DEF_PRIORITY_BITS = 4;
  localparam int unsigned FIELD_PRIO_W      = 4;
  localparam int unsigned FIELD_COUNT_W     = 5;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [31:0]        item_value;
    logic [FIELD_PRIO_W-1:0]   item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]        out_value;
    logic [FIELD_PRIO_W-1:0]   out_priority;
    logic                      out_valid;
    logic                      empty_error;
    logic                      full_error;
    logic [FIELD_COUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } spq_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// one slot of the sorted cell row: holds a value and its priority
// on insert it keeps, takes the new item or takes its left neighbor; on remove
// it takes its right neighbor. depends on spq_pkg
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                     clk,
  input  spq_ctrl_t                ctrl,
  input  logic                     occupied,
  input  logic signed [31:0]       new_value,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic                     left_stay,
  input  logic signed [31:0]       left_value,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic signed [31:0]       right_value,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic signed [31:0]       value,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     stay
);

  logic signed [31:0]       value_r, value_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  assign stay  = occupied && (prio_r <= new_prio);
  assign value = value_r;
  assign prio  = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    priority if (ctrl.shift_in) begin
      if (!stay) begin
        if (left_stay) begin
          value_nxt = new_value;
          prio_nxt  = new_prio;
        end else begin
          value_nxt = left_value;
          prio_nxt  = left_prio;
        end
      end
    end else if (ctrl.shift_out) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule

// File: rtl/stable_priority_queue_top.sv
// stable priority queue top level: command decode, entry count, result register
// and the row of sorting cells. depends on spq_pkg and spq_cell
//
// usage:
//   commands enter on in_item and are taken at a clock edge with start high and
//   busy low. busy stays low, so a push or a pop may be issued every cycle.
//   a push places its item after every stored entry of equal or better
//   (numerically lower or equal) priority; a pop removes and returns the head.
//   every command yields one result on out_data, marked by out_strobe for one
//   cycle, in the cycle right after the command was taken (throughput 1 item
//   per cycle). the whole row of cells shifts together when the command is
//   taken: each cell compares its priority with the new one and keeps, takes
//   the new item or takes its neighbor.
//   a push to a full queue is dropped and flagged in full_error; a pop from an
//   empty queue is flagged in empty_error. entry_count gives the fill level
//   after the command.
//   reset clears the entry count and the result strobe; cell contents are left
//   as they are and are never read before being written.
//   the receiver cannot stall: a result not taken in its cycle is gone.
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY      = DEF_CAPACITY,
  parameter int unsigned PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_strobe_r;
  out_item_t                out_data_r, out_data_nxt;

  logic                     accept;
  logic                     is_full, is_empty;
  spq_ctrl_t                ctrl;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic signed [31:0]       cell_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
  logic                     cell_stay  [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign new_prio = PRIORITY_BITS'(in_item.item_priority);

  always_comb begin
    ctrl.shift_in  = accept && (in_item.kind == KIND_PUSH) && !is_full;
    ctrl.shift_out = accept && (in_item.kind == KIND_POP) && !is_empty;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.shift_in) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.shift_out) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.entry_count  = FIELD_COUNT_W'(count_nxt);
    unique case (in_item.kind)
      KIND_PUSH: begin
        out_data_nxt.full_error = is_full;
      end
      KIND_POP: begin
        out_data_nxt.empty_error = is_empty;
        if (!is_empty) begin
          out_data_nxt.out_value    = cell_value[0];
          out_data_nxt.out_priority = FIELD_PRIO_W'(cell_prio[0]);
          out_data_nxt.out_valid    = 1'b1;
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_stay;
    logic signed [31:0]       left_value;
    logic [PRIORITY_BITS-1:0] left_prio;
    logic signed [31:0]       right_value;
    logic [PRIORITY_BITS-1:0] right_prio;

    if (i == 0) begin : g_head
      assign left_stay  = 1'b1;
      assign left_value = in_item.item_value;
      assign left_prio  = new_prio;
    end else begin : g_body
      assign left_stay  = cell_stay[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count_r),
      .new_value   (in_item.item_value),
      .new_prio    (new_prio),
      .left_stay   (left_stay),
      .left_value  (left_value),
      .left_prio   (left_prio),
      .right_value (right_value),
      .right_prio  (right_prio),
      .value       (cell_value[i]),
      .prio        (cell_prio[i]),
      .stay        (cell_stay[i])
    );
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("command without result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $countones({out_data.out_valid, out_data.empty_error,
                               out_data.full_error}) <= 1)
    else $error("conflicting result flags");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift_out |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not lower the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
    else $error("head entry out of order");

endmodule

// File: tb/sv/spq_order_checker.sv
`timescale 1ns / 100ps
// order checker for the stable priority queue: predicts each result from the
// accepted commands and compares it with the result channel. depends on spq_pkg
module spq_order_checker
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int unsigned DEPTH = DEF_CAPACITY;
  localparam logic [FIELD_PRIO_W-1:0] PRIO_MASK =
    FIELD_PRIO_W'((1 << DEF_PRIORITY_BITS) - 1);

  logic signed [31:0]      cell_value [DEPTH];
  logic [FIELD_PRIO_W-1:0] cell_prio  [DEPTH];
  int                      fill_level;
  out_item_t               predicted_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    fill_level = 0;
  end

  task automatic apply_queue_cmd(input in_item_t cmd, output out_item_t res);
    int pos;
    int i;
    logic [FIELD_PRIO_W-1:0] prio;
    res  = '0;
    prio = cmd.item_priority & PRIO_MASK;
    if (cmd.kind == KIND_PUSH) begin
      if (fill_level >= DEPTH) begin
        res.full_error = 1'b1;
      end else begin
        pos = 0;
        while (pos < fill_level && cell_prio[pos] <= prio) pos++;
        for (i = fill_level; i > pos; i--) begin
          cell_value[i] = cell_value[i-1];
          cell_prio[i]  = cell_prio[i-1];
        end
        cell_value[pos] = cmd.item_value;
        cell_prio[pos]  = prio;
        fill_level++;
      end
    end else begin
      if (fill_level == 0) begin
        res.empty_error = 1'b1;
      end else begin
        res.out_value    = cell_value[0];
        res.out_priority = cell_prio[0];
        res.out_valid    = 1'b1;
        for (i = 0; i + 1 < fill_level; i++) begin
          cell_value[i] = cell_value[i+1];
          cell_prio[i]  = cell_prio[i+1];
        end
        fill_level--;
      end
    end
    res.entry_count = fill_level[FIELD_COUNT_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t pred;
    out_item_t want;
    if (!rst_n) begin
      fill_level = 0;
      predicted_results.delete();
    end else begin
      if (start && !busy) begin
        apply_queue_cmd(in_item, pred);
        predicted_results.push_back(pred);
      end
      if (out_strobe) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no item pending", out_data.out_value, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.out_value !== want.out_value)
            report_mismatch("out_value", out_data.out_value, want.out_value);
          if (out_data.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(out_data.out_priority),
                            32'(want.out_priority));
          if (out_data.out_valid !== want.out_valid)
            report_mismatch("out_valid", 32'(out_data.out_valid),
                            32'(want.out_valid));
          if (out_data.empty_error !== want.empty_error)
            report_mismatch("empty_error", 32'(out_data.empty_error),
                            32'(want.empty_error));
          if (out_data.full_error !== want.full_error)
            report_mismatch("full_error", 32'(out_data.full_error),
                            32'(want.full_error));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_data.entry_count),
                            32'(want.entry_count));
        end
      end
    end
    pending <= predicted_results.size();
  end

endmodule

// File: tb/sv/tb_stable_priority_queue_top.sv
`timescale 1ns / 100ps
// testbench top for the stable priority queue: clock, reset, push and pop
// stimulus with random gaps, and the verdict. depends on spq_pkg, stable_priority_queue_top, spq_order_checker
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int NUM_RANDOM = 750;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  bit        no_idle;

  stable_priority_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  spq_order_checker u_order_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7fff_ffff;
    if (r == 1) return 32'sh8000_0000;
    if (r == 2) return '0;
    return $urandom;
  endfunction

  task automatic send_cmd(input kind_t kind, input logic signed [31:0] value,
                          input logic [FIELD_PRIO_W-1:0] prio);
    int gap;
    in_item_t cmd;
    cmd.kind          = kind;
    cmd.item_value    = value;
    cmd.item_priority = prio;
    gap = pick_gap();
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int n;
    int push_pct;
    bit narrow;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, value and priority extremes, ties, fill, full push
    send_cmd(KIND_POP, 32'sh1234_5678, 4'hf);
    send_cmd(KIND_PUSH, 32'sh7fff_ffff, 4'hf);
    send_cmd(KIND_PUSH, 32'sh8000_0000, 4'h0);
    send_cmd(KIND_PUSH, 32'sh0000_0000, 4'hf);
    send_cmd(KIND_PUSH, 32'shffff_ffff, 4'h7);
    send_cmd(KIND_PUSH, 32'sh0000_0001, 4'h0);
    for (n = 0; n < 11; n++) send_cmd(KIND_PUSH, $urandom, 4'($urandom_range(0, 15)));
    send_cmd(KIND_PUSH, 32'sh5555_aaaa, 4'h0);
    for (n = 0; n < 4; n++) send_cmd(KIND_POP, 32'shffff_ffff, 4'hf);

    // random: phases that lean to filling or draining, some with many ties
    push_pct = 50;
    narrow   = 1'b0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 85;
          1: push_pct = 20;
          2: push_pct = 50;
          default: push_pct = 65;
        endcase
        narrow  = ($urandom_range(0, 2) == 0);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct)
        send_cmd(KIND_PUSH, pick_value(),
                 narrow ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15)));
      else
        send_cmd(KIND_POP, $urandom, 4'($urandom_range(0, 15)));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
